[hdl/tsse_pkg.sv]
`timescale 1ns / 1ps
package tsse_pkg;

  localparam int unsigned PRED_W   = 24;
  localparam int unsigned COST_W   = 23;
  localparam int unsigned PPY_W    = 16;
  localparam int unsigned NET_W    = 26;
  localparam int unsigned SUM_W    = 42;
  localparam int unsigned SQS_W    = 64;
  localparam int unsigned SHARPE_W = 32;
  localparam int unsigned TURN_W   = 17;
  localparam int unsigned N_W      = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_COST      = 2'd1,
    CFG_PPY       = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_SQ  = 2'd0,
    MUL_NQ  = 2'd1,
    MUL_DEN = 2'd2,
    MUL_NUM = 2'd3
  } mul_sel_e;

  typedef enum logic {
    DIV_TURN   = 1'b0,
    DIV_SHARPE = 1'b1
  } div_sel_e;

  typedef struct packed {
    logic     accept;
    logic     finish;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     div_start;
    div_sel_e div_sel;
    logic     sqrt_start;
    logic     ld_k;
    logic     ld_s2;
    logic     ld_d;
    logic     ld_den;
    logic     ld_turn;
    logic     ld_sharpe;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic sqrt_done;
    logic skip;
    logic nq_le_s2;
  } dp_status_t;

endpackage

[hdl/tsse_ifs.sv]
`timescale 1ns / 1ps
interface tsse_day_if;
  logic                                valid;
  logic                                ready;
  logic signed [tsse_pkg::PRED_W-1:0]  prediction;
  logic signed [tsse_pkg::PRED_W-1:0]  actual_return;
  logic                                last_day;
  modport source (output valid, prediction, actual_return, last_day, input ready);
  modport sink (input valid, prediction, actual_return, last_day, output ready);
endinterface

interface tsse_res_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  position;
  logic signed [tsse_pkg::PRED_W-1:0]    gross_return;
  logic signed [tsse_pkg::NET_W-1:0]     net_return;
  logic                                  position_changed;
  logic                                  summary_valid;
  logic signed [tsse_pkg::SHARPE_W-1:0]  sharpe_ratio;
  logic [tsse_pkg::TURN_W-1:0]           mean_turnover;
  modport source (output valid, position, gross_return, net_return, position_changed,
                  summary_valid, sharpe_ratio, mean_turnover, input ready);
  modport sink (input valid, position, gross_return, net_return, position_changed,
                summary_valid, sharpe_ratio, mean_turnover, output ready);
endinterface

interface tsse_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [tsse_pkg::CFG_IDX_W-1:0]       index;
  logic [tsse_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/threshold_strategy_sharpe_evaluator_top.sv]
`timescale 1ns / 1ps
// Threshold strategy evaluator. Each day transaction gives one result
// transaction with the position, gross and net return and turnover flag. An
// ordinary day's result is registered, so days stream at one per cycle as
// long as results are taken. A day marked last_day also produces the
// annualized Sharpe ratio and mean turnover; the input stays stalled for
// that summary. It first runs a turnover pass of the bit-serial divider and
// ends there when fewer than two days, a zero net sum or zero periods per
// year force a zero ratio; else two of up to four shift-and-add multiplies
// (one multiplier bit per cycle) follow, and unless the deviation is zero,
// two more multiplies, a second divider pass and a 31-step square root.
// Configuration writes are always accepted and must be issued only while
// no day is in flight.
module threshold_strategy_sharpe_evaluator_top #(
  parameter int unsigned MAX_DAYS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsse_day_if.sink    day_i,
  tsse_res_if.source  res_o,
  tsse_cfg_if.sink    cfg_i
);
  import tsse_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_i.ready = 1'b1;

  tsse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (day_i.valid),
    .in_last_i   (day_i.last_day),
    .in_ready_o  (day_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tsse_dp #(
    .MAX_DAYS (MAX_DAYS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_i.valid),
    .cfg_index_i        (cfg_i.index),
    .cfg_data_i         (cfg_i.data),
    .prediction_i       (day_i.prediction),
    .actual_return_i    (day_i.actual_return),
    .last_day_i         (day_i.last_day),
    .position_o         (res_o.position),
    .gross_return_o     (res_o.gross_return),
    .net_return_o       (res_o.net_return),
    .position_changed_o (res_o.position_changed),
    .summary_valid_o    (res_o.summary_valid),
    .sharpe_ratio_o     (res_o.sharpe_ratio),
    .mean_turnover_o    (res_o.mean_turnover)
  );

endmodule

[hdl/tsse_ctrl.sv]
`timescale 1ns / 1ps
module tsse_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_last_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  tsse_pkg::dp_status_t   status_i,
  output tsse_pkg::ctrl_cmd_t    cmd_o
);
  import tsse_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_TURN_GO   = 12'b0000_0000_0010,
    S_TURN_WAIT = 12'b0000_0000_0100,
    S_CHK       = 12'b0000_0000_1000,
    S_SQ_WAIT   = 12'b0000_0001_0000,
    S_NQ_WAIT   = 12'b0000_0010_0000,
    S_DEN_GO    = 12'b0000_0100_0000,
    S_DEN_WAIT  = 12'b0000_1000_0000,
    S_NUM_WAIT  = 12'b0001_0000_0000,
    S_DIV_WAIT  = 12'b0010_0000_0000,
    S_ROOT_WAIT = 12'b0100_0000_0000,
    S_DONE      = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.accept = in_fire;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_last_i) begin
            state_d = S_TURN_GO;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_TURN_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_TURN;
        state_d         = S_TURN_WAIT;
      end
      S_TURN_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.ld_turn = 1'b1;
          state_d       = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.ld_k = 1'b1;
        if (status_i.skip) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_SQ;
          state_d         = S_SQ_WAIT;
        end
      end
      S_SQ_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.ld_s2     = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_NQ;
          state_d         = S_NQ_WAIT;
        end
      end
      S_NQ_WAIT: begin
        if (status_i.mul_done) begin
          if (status_i.nq_le_s2) begin
            state_d = S_DONE;
          end else begin
            cmd_o.ld_d = 1'b1;
            state_d    = S_DEN_GO;
          end
        end
      end
      S_DEN_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_DEN;
        state_d         = S_DEN_WAIT;
      end
      S_DEN_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.ld_den    = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_NUM;
          state_d         = S_NUM_WAIT;
        end
      end
      S_NUM_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_SHARPE;
          state_d         = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = S_ROOT_WAIT;
        end
      end
      S_ROOT_WAIT: begin
        if (status_i.sqrt_done) begin
          cmd_o.ld_sharpe = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hdl/tsse_dp.sv]
`timescale 1ns / 1ps
module tsse_dp #(
  parameter int unsigned MAX_DAYS = 65536
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  tsse_pkg::ctrl_cmd_t                    cmd_i,
  output tsse_pkg::dp_status_t                   status_o,
  input  logic                                   cfg_we_i,
  input  logic [tsse_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [tsse_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic signed [tsse_pkg::PRED_W-1:0]     prediction_i,
  input  logic signed [tsse_pkg::PRED_W-1:0]     actual_return_i,
  input  logic                                   last_day_i,
  output logic                                   position_o,
  output logic signed [tsse_pkg::PRED_W-1:0]     gross_return_o,
  output logic signed [tsse_pkg::NET_W-1:0]      net_return_o,
  output logic                                   position_changed_o,
  output logic                                   summary_valid_o,
  output logic signed [tsse_pkg::SHARPE_W-1:0]   sharpe_ratio_o,
  output logic [tsse_pkg::TURN_W-1:0]            mean_turnover_o
);
  import tsse_pkg::*;

  localparam int unsigned CntW   = $clog2(MAX_DAYS + 1);
  localparam int unsigned MagW   = SUM_W - 1;
  localparam int unsigned S2W    = 2 * MagW;
  localparam int unsigned KW     = N_W + PPY_W;
  localparam int unsigned DenW   = S2W + N_W;
  localparam int unsigned ProdW  = S2W + KW;
  localparam int unsigned DvdW   = ProdW + 33;
  localparam int unsigned DcntW  = $clog2(DvdW + 1);
  localparam int unsigned QuoW   = 63;
  localparam int unsigned RootW  = 62;
  localparam logic signed [SUM_W:0] SumMax = 43'sd2199023255551;

  // Configuration registers.
  logic signed [PRED_W-1:0] thr_q;
  logic [COST_W-1:0]        cost_q;
  logic [PPY_W-1:0]         ppy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      cost_q <= '0;
      ppy_q  <= PPY_W'(252);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_THRESHOLD: thr_q  <= $signed(cfg_data_i[PRED_W-1:0]);
        CFG_COST:      cost_q <= cfg_data_i[COST_W-1:0];
        CFG_PPY:       ppy_q  <= cfg_data_i[PPY_W-1:0];
        default: ;
      endcase
    end
  end

  // Daily path.
  logic                     prev_q;
  logic [CntW-1:0]          cnt_q;
  logic [CntW-1:0]          cc_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [SQS_W-1:0]         sqs_q;

  logic                     pos, chg;
  logic signed [PRED_W-1:0] gross;
  logic signed [NET_W-1:0]  net;
  logic [PRED_W:0]          mag;
  logic [2*PRED_W+1:0]      sq;
  logic signed [SUM_W:0]    sum_nx;
  logic signed [SUM_W-1:0]  sum_d;
  logic [SQS_W:0]           sqs_nx;
  logic [SQS_W-1:0]         sqs_d;

  always_comb begin
    pos    = prediction_i > thr_q;
    chg    = pos ^ prev_q;
    gross  = pos ? actual_return_i : '0;
    net    = NET_W'(gross) - (chg ? $signed(NET_W'(cost_q)) : '0);
    mag    = net[NET_W-1] ? (PRED_W+1)'(-net) : net[PRED_W:0];
    sq     = (2*PRED_W+2)'(mag) * (2*PRED_W+2)'(mag);
    sum_nx = (SUM_W+1)'(sum_q) + (SUM_W+1)'(net);
    if (sum_nx > SumMax) begin
      sum_d = SumMax[SUM_W-1:0];
    end else if (sum_nx < -SumMax) begin
      sum_d = -SumMax[SUM_W-1:0];
    end else begin
      sum_d = sum_nx[SUM_W-1:0];
    end
    sqs_nx = (SQS_W+1)'(sqs_q) + (SQS_W+1)'(sq);
    sqs_d  = sqs_nx[SQS_W] ? '1 : sqs_nx[SQS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      cnt_q  <= '0;
      cc_q   <= '0;
      sum_q  <= '0;
      sqs_q  <= '0;
    end else if (cmd_i.finish) begin
      prev_q <= 1'b0;
      cnt_q  <= '0;
      cc_q   <= '0;
      sum_q  <= '0;
      sqs_q  <= '0;
    end else if (cmd_i.accept) begin
      prev_q <= pos;
      if (cnt_q < CntW'(MAX_DAYS)) begin
        cnt_q <= cnt_q + CntW'(1);
        cc_q  <= cc_q + CntW'(chg);
        sum_q <= sum_d;
        sqs_q <= sqs_d;
      end
    end
  end

  // Result registers.
  logic                     pos_q, chg_q, sumv_q;
  logic signed [PRED_W-1:0] gross_q;
  logic signed [NET_W-1:0]  net_q;
  logic signed [SHARPE_W-1:0] sharpe_q;
  logic [TURN_W-1:0]        turn_q;

  // Summary operands.
  logic [N_W-1:0]     n17;
  logic [MagW-1:0]    smag;
  logic [KW-1:0]      k_q;
  logic [S2W-1:0]     s2_q;
  logic [S2W-1:0]     d_q;
  logic [DenW-1:0]    den_q;

  assign n17  = N_W'(cnt_q);
  assign smag = sum_q[SUM_W-1] ? MagW'(-sum_q) : sum_q[MagW-1:0];

  // Shift-and-add multiplier, one multiplier bit per cycle.
  logic [ProdW-1:0] mc_q, acc_q, mc_in;
  logic [MagW-1:0]  mp_q, mp_in;
  logic             mbusy_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SQ: begin
        mc_in = ProdW'(smag);
        mp_in = smag;
      end
      MUL_NQ: begin
        mc_in = ProdW'(sqs_q);
        mp_in = MagW'(n17);
      end
      MUL_DEN: begin
        mc_in = ProdW'(d_q);
        mp_in = MagW'(n17);
      end
      MUL_NUM: begin
        mc_in = ProdW'(s2_q);
        mp_in = MagW'(k_q);
      end
      default: begin
        mc_in = '0;
        mp_in = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
    end else if (cmd_i.mul_start) begin
      mbusy_q <= 1'b1;
    end else if (mbusy_q && mp_q == '0) begin
      mbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mc_q  <= mc_in;
      mp_q  <= mp_in;
      acc_q <= '0;
    end else if (mbusy_q && mp_q != '0) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q << 1;
      mp_q <= mp_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_k) begin
      k_q <= KW'(n17 - N_W'(1)) * KW'(ppy_q);
    end
    if (cmd_i.ld_s2) begin
      s2_q <= acc_q[S2W-1:0];
    end
    if (cmd_i.ld_d) begin
      d_q <= acc_q[S2W-1:0] - s2_q;
    end
    if (cmd_i.ld_den) begin
      den_q <= acc_q[DenW-1:0];
    end
  end

  // Restoring divider, one quotient bit per cycle. The quotient saturates
  // at 2^62, which is enough to decide the root against its 2^31 ceiling.
  logic [DvdW-1:0]  dvd_q, dvd_in;
  logic [DenW-1:0]  dvs_q, dvs_in, rem_q, rem_d;
  logic [DenW:0]    r2;
  logic             ge;
  logic [QuoW-1:0]  quo_q;
  logic             qsat_q;
  logic [DcntW-1:0] dcnt_q;
  logic             dbusy_q;

  always_comb begin
    if (cmd_i.div_sel == DIV_TURN) begin
      dvd_in = DvdW'({cc_q, 16'h0000});
      dvs_in = DenW'(n17);
    end else begin
      dvd_in = DvdW'({acc_q, 32'h0000_0000});
      dvs_in = den_q;
    end
    r2    = {rem_q, dvd_q[DvdW-1]};
    ge    = r2 >= {1'b0, dvs_q};
    rem_d = ge ? DenW'(r2 - {1'b0, dvs_q}) : r2[DenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= 1'b1;
    end else if (dbusy_q && dcnt_q == '0) begin
      dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q  <= dvd_in;
      dvs_q  <= dvs_in;
      rem_q  <= '0;
      quo_q  <= '0;
      qsat_q <= 1'b0;
      dcnt_q <= DcntW'(DvdW);
    end else if (dbusy_q && dcnt_q != '0) begin
      dvd_q  <= dvd_q << 1;
      rem_q  <= rem_d;
      quo_q  <= {quo_q[QuoW-2:0], ge};
      qsat_q <= qsat_q | quo_q[QuoW-2];
      dcnt_q <= dcnt_q - DcntW'(1);
    end
  end

  // Digit-by-digit integer square root, one result bit per cycle.
  logic [RootW-1:0] op_q, res_q, one_q, trial;
  logic             sbusy_q;

  assign trial = res_q + one_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
    end else if (cmd_i.sqrt_start) begin
      sbusy_q <= 1'b1;
    end else if (sbusy_q && one_q == '0) begin
      sbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      op_q  <= quo_q[RootW-1:0];
      res_q <= '0;
      one_q <= RootW'(1) << (RootW - 2);
    end else if (sbusy_q && one_q != '0) begin
      if (op_q >= trial) begin
        op_q  <= op_q - trial;
        res_q <= (res_q >> 1) + one_q;
      end else begin
        res_q <= res_q >> 1;
      end
      one_q <= one_q >> 2;
    end
  end

  logic [SHARPE_W-1:0] rmag;
  assign rmag = qsat_q ? {1'b1, {(SHARPE_W-1){1'b0}}} : {1'b0, res_q[SHARPE_W-2:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_q    <= pos;
      chg_q    <= chg;
      gross_q  <= gross;
      net_q    <= net;
      sumv_q   <= last_day_i;
      sharpe_q <= '0;
      turn_q   <= '0;
    end else begin
      if (cmd_i.ld_turn) begin
        turn_q <= quo_q[TURN_W-1:0];
      end
      if (cmd_i.ld_sharpe) begin
        if (sum_q[SUM_W-1]) begin
          sharpe_q <= $signed(-rmag);
        end else if (qsat_q) begin
          sharpe_q <= {1'b0, {(SHARPE_W-1){1'b1}}};
        end else begin
          sharpe_q <= $signed(rmag);
        end
      end
    end
  end

  assign status_o.mul_done  = mbusy_q && (mp_q == '0);
  assign status_o.div_done  = dbusy_q && (dcnt_q == '0);
  assign status_o.sqrt_done = sbusy_q && (one_q == '0);
  assign status_o.skip      = (n17 < N_W'(2)) || (ppy_q == '0) || (sum_q == '0);
  assign status_o.nq_le_s2  = acc_q <= ProdW'(s2_q);

  assign position_o         = pos_q;
  assign gross_return_o     = gross_q;
  assign net_return_o       = net_q;
  assign position_changed_o = chg_q;
  assign summary_valid_o    = sumv_q;
  assign sharpe_ratio_o     = sharpe_q;
  assign mean_turnover_o    = turn_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import tsse_pkg::*;

  localparam int unsigned CLK_HALF     = 4;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned DAY_LIMIT    = 65536;
  localparam int unsigned LONG_LEN     = 200;
  localparam int unsigned SETTLE_CYC   = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint NET_SUM_MAX = 64'sd2199023255551;

  typedef logic [191:0] wide_t;

  typedef struct {
    logic        position;
    logic [23:0] gross;
    logic [25:0] net;
    logic        changed;
    logic        summary;
    logic [31:0] sharpe;
    logic [16:0] turnover;
  } day_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tsse_day_if day_bus ();
  tsse_res_if res_bus ();
  tsse_cfg_if cfg_bus ();

  threshold_strategy_sharpe_evaluator_top #(.MAX_DAYS(DAY_LIMIT)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .day_i  (day_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Predictor copy of the registers and the series state.
  logic signed [23:0] thr_q;
  logic [22:0]        cost_q;
  logic [15:0]        ppy_q;
  logic               prev_pos;
  int unsigned        day_cnt;
  longint             net_acc;
  logic [63:0]        sq_acc;
  int unsigned        chg_cnt;

  day_result_t expected_days[$];
  int unsigned errors = 0;
  int unsigned days_sent = 0;
  int unsigned summaries_seen = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_req = 0;

  function automatic logic [31:0] series_sharpe();
    wide_t s2, nq, dev, den, num, t;
    logic [63:0] mag, lo, hi, mid;
    longint unsigned n;
    n = day_cnt;
    if (n < 2 || ppy_q == 0 || net_acc == 0) return 32'd0;
    mag = (net_acc < 0) ? 64'(-net_acc) : 64'(net_acc);
    s2 = wide_t'(mag) * wide_t'(mag);
    nq = wide_t'(sq_acc) * wide_t'(n);
    if (nq <= s2) return 32'd0;
    dev = nq - s2;
    den = dev * wide_t'(n);
    num = (s2 * wide_t'((n - 1) * ppy_q)) << 32;
    lo = 0;
    hi = 64'd1 << 31;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = wide_t'(mid * mid) * den;
      if (t <= num) lo = mid;
      else hi = mid - 1;
    end
    if (net_acc < 0) return 32'(-lo);
    if (lo > 64'd2147483647) return 32'h7fffffff;
    return lo[31:0];
  endfunction

  task automatic clear_series();
    prev_pos = 1'b0;
    day_cnt  = 0;
    net_acc  = 0;
    sq_acc   = 64'd0;
    chg_cnt  = 0;
  endtask

  task automatic predict_day(input logic signed [23:0] pred, input logic signed [23:0] ret,
                             input logic last);
    day_result_t r;
    longint net;
    logic [63:0] mag, sq;
    r.position = (pred > thr_q);
    r.changed  = (r.position != prev_pos);
    r.gross    = r.position ? ret : 24'd0;
    net        = (r.position ? longint'(ret) : 0) - (r.changed ? longint'(cost_q) : 0);
    r.net      = net[25:0];
    r.summary  = last;
    r.sharpe   = 32'd0;
    r.turnover = 17'd0;
    prev_pos   = r.position;
    if (day_cnt < DAY_LIMIT) begin
      mag = (net < 0) ? 64'(-net) : 64'(net);
      sq  = mag * mag;
      day_cnt++;
      chg_cnt += r.changed;
      net_acc += net;
      if (net_acc > NET_SUM_MAX) net_acc = NET_SUM_MAX;
      if (net_acc < -NET_SUM_MAX) net_acc = -NET_SUM_MAX;
      sq_acc = (sq_acc > ~64'd0 - sq) ? ~64'd0 : sq_acc + sq;
    end
    if (last) begin
      r.sharpe = series_sharpe();
      if (day_cnt != 0) r.turnover = 17'((longint'(chg_cnt) << 16) / day_cnt);
      clear_series();
    end
    expected_days.insert(expected_days.size(), r);
  endtask

  task automatic send_day(input logic [23:0] pred, input logic [23:0] ret, input logic last);
    int unsigned gap;
    day_bus.valid         <= 1'b1;
    day_bus.prediction    <= pred;
    day_bus.actual_return <= ret;
    day_bus.last_day      <= last;
    @(posedge clk_i);
    while (!day_bus.ready) @(posedge clk_i);
    predict_day(pred, ret, last);
    days_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      day_bus.valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    day_bus.valid <= 1'b0;
    while (expected_days.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_THRESHOLD: thr_q  = value;
      CFG_COST:      cost_q = value[22:0];
      CFG_PPY:       ppy_q  = value[15:0];
      default: ;
    endcase
  endtask

  task automatic send_series(input int unsigned len, input int unsigned flavor);
    logic [23:0] p, r;
    for (int unsigned i = 0; i < len; i++) begin
      case (flavor)
        0: begin
          p = $urandom;
          r = $urandom;
        end
        1: begin
          // Predictions close to the threshold keep the position switching.
          p = thr_q + 24'($urandom_range(0, 6)) - 24'd3;
          r = 24'($urandom_range(0, 4000)) - 24'd2000;
        end
        default: begin
          p = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
          r = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
        end
      endcase
      send_day(p, r, i == len - 1);
    end
  endtask

  task automatic test_defaults();
    send_day(24'h7fffff, 24'h7fffff, 1'b0);
    send_day(24'h800000, 24'h800000, 1'b0);
    send_day(24'h000001, 24'h800000, 1'b0);
    send_day(24'h000000, 24'h123456, 1'b1);
    // A one-day series gives a zero ratio but still a turnover.
    send_day(24'h000010, 24'h000100, 1'b1);
    send_day(24'h800000, 24'h7fffff, 1'b1);
  endtask

  task automatic test_registers();
    write_reg(CFG_THRESHOLD, 24'h800000);
    write_reg(CFG_COST, 24'h7fffff);
    write_reg(CFG_PPY, 24'h00ffff);
    send_day(24'h800000, 24'h7fffff, 1'b0);
    send_day(24'h800001, 24'h800000, 1'b0);
    send_day(24'h800000, 24'h800000, 1'b1);
    write_reg(CFG_THRESHOLD, 24'h7fffff);
    write_reg(CFG_PPY, 24'h000001);
    send_day(24'h7fffff, 24'h7fffff, 1'b0);
    send_day(24'h7fffff, 24'h000040, 1'b1);
    // An unmapped index must leave every register as it was.
    write_reg(CFG_UNUSED, 24'hffffff);
    write_reg(CFG_COST, 24'hffffff);
    send_day(24'h000000, 24'h000040, 1'b1);
  endtask

  task automatic test_ratio_cases();
    write_reg(CFG_THRESHOLD, 24'h000000);
    write_reg(CFG_COST, 24'h000000);
    write_reg(CFG_PPY, 24'h00ffff);
    // Near-constant gains give a ratio past the positive limit.
    for (int i = 0; i < 6; i++) send_day(24'h000100, (i == 2) ? 24'd1001 : 24'd1000, i == 5);
    for (int i = 0; i < 6; i++)
      send_day(24'h000100, (i == 2) ? -24'sd1001 : -24'sd1000, i == 5);
    // Identical net returns leave no deviation.
    for (int i = 0; i < 4; i++) send_day(24'h000100, 24'd5000, i == 3);
    write_reg(CFG_PPY, 24'd252);
  endtask

  task automatic test_random_series();
    int unsigned target;
    target = days_sent + 1200;
    while (days_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: write_reg(CFG_THRESHOLD, $urandom);
          1: write_reg(CFG_COST, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 5000));
          default: write_reg(CFG_PPY, $urandom_range(0, 3) == 0 ? 24'(($urandom & 24'hfffe) | 1)
                                                               : 24'($urandom_range(1, 400)));
        endcase
      end
      send_series($urandom_range(0, 7) == 0 ? 1 : $urandom_range(2, 30), $urandom_range(0, 2));
    end
  endtask

  task automatic test_backpressure();
    hold_req = 400;
    send_series(60, 1);
    send_series(5, 0);
  endtask

  task automatic test_long_series();
    logic [23:0] r;
    idle_on = 1'b0;
    write_reg(CFG_COST, 24'd300);
    write_reg(CFG_THRESHOLD, 24'h000000);
    // A long series sent back to back with no idle cycles on either side.
    for (int unsigned i = 0; i < LONG_LEN; i++) begin
      r = 24'($urandom_range(0, 8000)) - 24'd3000;
      send_day($urandom_range(0, 3) == 0 ? 24'hfff000 : 24'h000400, r, i == LONG_LEN - 1);
    end
    send_series(20, 0);
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    day_result_t e;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_days.size() == 0) begin
        $display("%0t unexpected result transaction", $time);
        errors++;
      end else begin
        e = expected_days.pop_front();
        check_field("position", e.position, res_bus.position);
        check_field("gross_return", e.gross, res_bus.gross_return[23:0]);
        check_field("net_return", e.net, res_bus.net_return[25:0]);
        check_field("position_changed", e.changed, res_bus.position_changed);
        check_field("summary_valid", e.summary, res_bus.summary_valid);
        check_field("sharpe_ratio", e.sharpe, res_bus.sharpe_ratio[31:0]);
        check_field("mean_turnover", e.turnover, res_bus.mean_turnover);
        if (e.summary) summaries_seen++;
      end
    end
  end

  int unsigned stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req = 0;
      res_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      res_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni                <= 1'b0;
    day_bus.valid         <= 1'b0;
    day_bus.prediction    <= '0;
    day_bus.actual_return <= '0;
    day_bus.last_day      <= 1'b0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= CFG_THRESHOLD;
    cfg_bus.data          <= '0;
    thr_q  = 24'sd0;
    cost_q = 23'd0;
    ppy_q  = 16'd252;
    clear_series();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_registers();
    test_ratio_cases();
    test_random_series();
    test_backpressure();
    test_long_series();

    drain();
    $display("Sent %0d days in total, %0d series summaries checked,", days_sent, summaries_seen);
    $display("covering register extremes, ratio saturation, back-pressure and a long series.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/tsse_pkg.sv
hdl/tsse_ifs.sv
hdl/tsse_ctrl.sv
hdl/tsse_dp.sv
hdl/threshold_strategy_sharpe_evaluator_top.sv
tb/tb.sv
